// File: rtl/core/integer_power_with_overflow_guard_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the integer power unit
// Concurrent checks that compile away when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef INTEGER_POWER_WITH_OVERFLOW_GUARD_UNIT_ASSERT_SVH
`define INTEGER_POWER_WITH_OVERFLOW_GUARD_UNIT_ASSERT_SVH

`ifndef SYNTH

// same-cycle implication
`define IPOW_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ipow assertion failed: same-cycle implication");

// next-cycle implication
`define IPOW_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ipow assertion failed: next-cycle implication");

`else

`define IPOW_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define IPOW_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// File: rtl/core/ipow_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ipow_pkg
// Shared widths, result codes and handoff types of the integer power unit.
// ---------------------------------------------------------------------------
package ipow_pkg;

   localparam int DATA_BITS     = 64;
   localparam int HALF_BITS     = 32;
   localparam int PROD_BITS     = 128;
   localparam int CNT_BITS      = 6;   // exponent magnitude below 63
   localparam int MUL_CNT_BITS  = 3;
   localparam int WORD_BITS_DEF = 64;

   localparam logic [MUL_CNT_BITS-1:0] MUL_LAST = 3'd4;

   // result kinds
   localparam logic [1:0] KIND_POW   = 2'd0;
   localparam logic [1:0] KIND_RECIP = 2'd1;
   localparam logic [1:0] KIND_DIV0  = 2'd2;
   localparam logic [1:0] KIND_RANGE = 2'd3;

   localparam logic [DATA_BITS-1:0] MOST_NEG = {1'b1, {(DATA_BITS-1){1'b0}}};
   localparam logic [DATA_BITS-1:0] ALL_ONES = {DATA_BITS{1'b1}};

   // special-case decode outcome
   typedef struct packed {
      logic                 done;    // result known without multiplying
      logic [1:0]           kind;
      logic [DATA_BITS-1:0] value;
      logic [DATA_BITS-1:0] mag;     // base magnitude
      logic [CNT_BITS-1:0]  count;   // exponent magnitude
      logic                 neg;     // result is negative
      logic                 recip;   // negative exponent
   } ipow_dec_type;

   // multiplier outcome
   typedef struct packed {
      logic [DATA_BITS-1:0] low;
      logic                 big;     // product exceeds the signed word
   } ipow_prod_type;

endpackage

// File: rtl/core/ipow_decode.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ipow_decode
// Sorts a request into its special cases or sets up a square-and-multiply run.
// ---------------------------------------------------------------------------
module ipow_decode #(
   parameter int WORD_BITS = ipow_pkg::WORD_BITS_DEF
) (
   input  logic signed [ipow_pkg::DATA_BITS-1:0] base,
   input  logic signed [ipow_pkg::DATA_BITS-1:0] exponent,
   output ipow_pkg::ipow_dec_type                dec
);
   import ipow_pkg::*;

   localparam logic [DATA_BITS-1:0] LIMIT =
      (DATA_BITS'(1) << (WORD_BITS - 1)) - DATA_BITS'(1);
   localparam logic [DATA_BITS-1:0] EXP_LIMIT = DATA_BITS'(WORD_BITS - 1);

   logic [DATA_BITS-1:0] x;
   logic [DATA_BITS-1:0] y;
   logic [DATA_BITS-1:0] xmag;
   logic [DATA_BITS-1:0] ymag;

   assign x    = base;
   assign y    = exponent;
   assign xmag = x[DATA_BITS-1] ? (DATA_BITS'(0) - x) : x;
   assign ymag = y[DATA_BITS-1] ? (DATA_BITS'(0) - y) : y;

   // pick the first case that applies
   always_comb begin
      dec.done  = 1'b1;
      dec.kind  = KIND_POW;
      dec.value = '0;
      dec.mag   = xmag;
      dec.count = ymag[CNT_BITS-1:0];
      dec.neg   = x[DATA_BITS-1] & ymag[0];
      dec.recip = y[DATA_BITS-1];
      if (x == '0) begin
         if (y == '0) begin
            dec.value = DATA_BITS'(1);
         end else if (y[DATA_BITS-1]) begin
            dec.kind = KIND_DIV0;
         end
      end else if (y == DATA_BITS'(1)) begin
         dec.value = x;
      end else if (y == '0) begin
         dec.value = DATA_BITS'(1);
      end else if (x == DATA_BITS'(1)) begin
         dec.value = DATA_BITS'(1);
      end else if (x == ALL_ONES) begin
         dec.value = y[0] ? ALL_ONES : DATA_BITS'(1);
      end else if (y == MOST_NEG) begin
         dec.value = '0;
      end else if (x == MOST_NEG) begin
         dec.kind = KIND_RANGE;
      end else if ((ymag >= EXP_LIMIT) || (xmag > LIMIT)) begin
         // exponent too large for any base of two or more, or base beyond word
         dec.kind = KIND_RANGE;
      end else begin
         dec.done = 1'b0;
      end
   end

endmodule

// File: rtl/core/ipow_mul.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ipow_mul
// 64x64 unsigned multiplier built from one 32x32 array, one partial product at a time.
// ---------------------------------------------------------------------------
module ipow_mul #(
   parameter int WORD_BITS = ipow_pkg::WORD_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [ipow_pkg::DATA_BITS-1:0] op_a,
   input  logic [ipow_pkg::DATA_BITS-1:0] op_b,
   output logic                           busy,
   output logic                           done,
   output ipow_pkg::ipow_prod_type        result
);
   import ipow_pkg::*;

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [MUL_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [DATA_BITS-1:0]    a_ff, a_in;
   logic [DATA_BITS-1:0]    b_ff, b_in;
   logic [DATA_BITS-1:0]    pp_ff, pp_in;
   logic [PROD_BITS-1:0]    acc_ff, acc_in;
   logic [HALF_BITS-1:0]    half_a;
   logic [HALF_BITS-1:0]    half_b;
   logic [PROD_BITS-1:0]    addend;

   // select the halves for this partial product
   assign half_a = cnt_ff[1] ? a_ff[DATA_BITS-1:HALF_BITS] : a_ff[HALF_BITS-1:0];
   assign half_b = cnt_ff[0] ? b_ff[DATA_BITS-1:HALF_BITS] : b_ff[HALF_BITS-1:0];

   // align the partial product registered last cycle
   always_comb begin
      case (cnt_ff)
         3'd1:    addend = {{DATA_BITS{1'b0}}, pp_ff};
         3'd2,
         3'd3:    addend = {{HALF_BITS{1'b0}}, pp_ff, {HALF_BITS{1'b0}}};
         3'd4:    addend = {pp_ff, {DATA_BITS{1'b0}}};
         default: addend = '0;
      endcase
   end

   // advance the partial product sequence
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      pp_in   = pp_ff;
      acc_in  = acc_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         a_in    = op_a;
         b_in    = op_b;
         acc_in  = '0;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + MUL_CNT_BITS'(1);
         pp_in  = half_a * half_b;
         acc_in = acc_ff + addend;
         if (cnt_ff == MUL_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      pp_ff  <= pp_in;
      acc_ff <= acc_in;
   end

   assign busy       = busy_ff;
   assign done       = done_ff;
   assign result.low = acc_ff[DATA_BITS-1:0];
   assign result.big = |acc_ff[PROD_BITS-1:WORD_BITS-1];

endmodule

// File: rtl/core/integer_power_with_overflow_guard_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// integer_power_with_overflow_guard_unit
// Exact signed integer power by square-and-multiply with an overflow guard.
// ---------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid / req_stall) carries base and exponent.
//   Response channel (rsp_valid / rsp_stall) returns kind and value:
//   power, reciprocal denominator, divide by zero or out of range.
//   One request is in flight at a time; req_stall is high from acceptance
//   until the result has moved into the response register.
// Sequence:
//   Special cases (zero, one, minus one, exponent 0 or 1, extreme values,
//   guard failures visible from the operands) go from the decode state
//   straight to the done state. Otherwise the m multiplications run one
//   at a time on the shared 32x32-based multiplier; an exponent of
//   magnitude n takes floor(log2 n) squarings plus (ones in n) - 1
//   accumulations, m at most 9, and a product that overflows ends the run
//   early. The done state loads the response register once it is free.
// Requests: a new request can be taken in the cycle after the response
//   register loads; the unit is through with the last one by then.
// Reset clears the sequencer and the response valid. While rsp_stall is
// high the response holds; a new request may be accepted meanwhile, and
// its result waits in the unit until the response register frees.
// ---------------------------------------------------------------------------
`include "integer_power_with_overflow_guard_unit_assert.svh"

module integer_power_with_overflow_guard_unit #(
   parameter int WORD_BITS = ipow_pkg::WORD_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [ipow_pkg::DATA_BITS-1:0] req_base,
   input  logic signed [ipow_pkg::DATA_BITS-1:0] req_exponent,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [1:0]                            rsp_kind,
   output logic signed [ipow_pkg::DATA_BITS-1:0] rsp_value
);
   import ipow_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DECODE = 3'd1;
   localparam logic [2:0] ST_STEP   = 3'd2;
   localparam logic [2:0] ST_WAIT   = 3'd3;
   localparam logic [2:0] ST_DONE   = 3'd4;

   logic [2:0]           state_ff, state_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           rsp_kind_ff, rsp_kind_in;
   logic [DATA_BITS-1:0] rsp_value_ff, rsp_value_in;
   logic [DATA_BITS-1:0] base_ff, base_in;
   logic [DATA_BITS-1:0] exp_ff, exp_in;
   logic [DATA_BITS-1:0] acc_ff, acc_in;
   logic [DATA_BITS-1:0] sq_ff, sq_in;
   logic [CNT_BITS-1:0]  n_ff, n_in;
   logic                 acc_one_ff, acc_one_in;
   logic                 sq_op_ff, sq_op_in;
   logic                 neg_ff, neg_in;
   logic                 recip_ff, recip_in;
   logic [1:0]           res_kind_ff, res_kind_in;
   logic [DATA_BITS-1:0] res_value_ff, res_value_in;

   ipow_dec_type         dec;
   ipow_prod_type        prod;
   logic                 mul_start;
   logic                 mul_busy;
   logic                 mul_done;
   logic [DATA_BITS-1:0] mul_a;
   logic [DATA_BITS-1:0] mul_b;

   ipow_decode #(.WORD_BITS(WORD_BITS)) u_decode (
      .base     (base_ff),
      .exponent (exp_ff),
      .dec      (dec)
   );

   ipow_mul #(.WORD_BITS(WORD_BITS)) u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .op_a   (mul_a),
      .op_b   (mul_b),
      .busy   (mul_busy),
      .done   (mul_done),
      .result (prod)
   );

   // sequence one request through decode and square-and-multiply
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_kind_in  = rsp_kind_ff;
      rsp_value_in = rsp_value_ff;
      base_in      = base_ff;
      exp_in       = exp_ff;
      acc_in       = acc_ff;
      sq_in        = sq_ff;
      n_in         = n_ff;
      acc_one_in   = acc_one_ff;
      sq_op_in     = sq_op_ff;
      neg_in       = neg_ff;
      recip_in     = recip_ff;
      res_kind_in  = res_kind_ff;
      res_value_in = res_value_ff;
      mul_start    = 1'b0;
      mul_a        = acc_ff;
      mul_b        = sq_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               base_in  = req_base;
               exp_in   = req_exponent;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (dec.done) begin
               res_kind_in  = dec.kind;
               res_value_in = dec.value;
               state_in     = ST_DONE;
            end else begin
               sq_in      = dec.mag;
               acc_in     = DATA_BITS'(1);
               acc_one_in = 1'b1;
               n_in       = dec.count;
               neg_in     = dec.neg;
               recip_in   = dec.recip;
               state_in   = ST_STEP;
            end
         end
         ST_STEP: begin
            if (n_ff[0]) begin
               if (acc_one_ff) begin
                  // first factor: take the square directly
                  acc_in     = sq_ff;
                  acc_one_in = 1'b0;
                  n_in[0]    = 1'b0;
               end else begin
                  mul_start = 1'b1;
                  sq_op_in  = 1'b0;
                  state_in  = ST_WAIT;
               end
            end else if (n_ff[CNT_BITS-1:1] == '0) begin
               res_kind_in  = recip_ff ? KIND_RECIP : KIND_POW;
               res_value_in = neg_ff ? (DATA_BITS'(0) - acc_ff) : acc_ff;
               state_in     = ST_DONE;
            end else begin
               mul_start = 1'b1;
               mul_a     = sq_ff;
               sq_op_in  = 1'b1;
               state_in  = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (mul_done) begin
               if (prod.big) begin
                  res_kind_in  = KIND_RANGE;
                  res_value_in = '0;
                  state_in     = ST_DONE;
               end else if (sq_op_ff) begin
                  sq_in    = prod.low;
                  n_in     = n_ff >> 1;
                  state_in = ST_STEP;
               end else begin
                  acc_in   = prod.low;
                  n_in[0]  = 1'b0;
                  state_in = ST_STEP;
               end
            end
         end
         ST_DONE: begin
            // hand off once the response register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = res_kind_ff;
               rsp_value_in = res_value_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_kind_ff  <= rsp_kind_in;
      rsp_value_ff <= rsp_value_in;
      base_ff      <= base_in;
      exp_ff       <= exp_in;
      acc_ff       <= acc_in;
      sq_ff        <= sq_in;
      n_ff         <= n_in;
      acc_one_ff   <= acc_one_in;
      sq_op_ff     <= sq_op_in;
      neg_ff       <= neg_in;
      recip_ff     <= recip_in;
      res_kind_ff  <= res_kind_in;
      res_value_ff <= res_value_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_kind  = rsp_kind_ff;
   assign rsp_value = rsp_value_ff;

   // checks
   `IPOW_ASSERT_NEXT(a_accept_decode, clock, reset, req_valid && !req_stall, state_ff == ST_DECODE)
   `IPOW_ASSERT_IMPLY(a_mul_free, clock, reset, mul_start, !mul_busy && state_ff == ST_STEP)
   `IPOW_ASSERT_IMPLY(a_flag_zero, clock, reset,
      rsp_valid_ff && (rsp_kind_ff == KIND_DIV0 || rsp_kind_ff == KIND_RANGE), rsp_value_ff == '0)
   `IPOW_ASSERT_IMPLY(a_wait_busy, clock, reset, state_ff == ST_WAIT && !mul_done, mul_busy)

endmodule
